>>> hw/rtl/pbc_pkg.sv
// Shared widths, codes and defaults for the panel bridge CSR device.
`timescale 1ns / 1ps

package pbc_pkg;

   localparam int WORD_WIDTH   = 16;
   localparam int ACTION_WIDTH = 2;
   localparam int REG_WIDTH    = 3;
   localparam int MODE_WIDTH   = 2;
   localparam int CSR_IDX_WIDTH = 2;

   localparam int PERIOD_MAX_DEFAULT = 1000;

   // Request actions
   localparam logic [ACTION_WIDTH-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_WRITE = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_INIT  = 2'd3;

   // Bus register indexes
   localparam logic [REG_WIDTH-1:0] REG_ICS        = 3'd0;
   localparam logic [REG_WIDTH-1:0] REG_OCS        = 3'd1;
   localparam logic [REG_WIDTH-1:0] REG_IPER       = 3'd2;
   localparam logic [REG_WIDTH-1:0] REG_OPER       = 3'd3;
   localparam logic [REG_WIDTH-1:0] REG_CHANGE     = 3'd4;
   localparam logic [REG_WIDTH-1:0] REG_PANEL_WORD = 3'd5;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CFG_IN_PERIOD  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CFG_OUT_PERIOD = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CFG_PANEL_WORD = 2'd2;

   localparam logic [WORD_WIDTH-1:0] CFG_IN_PERIOD_RESET  = 16'd50;
   localparam logic [WORD_WIDTH-1:0] CFG_OUT_PERIOD_RESET = 16'd10;
   localparam logic [WORD_WIDTH-1:0] CFG_PANEL_WORD_RESET = 16'd0;

   // CSR bit positions
   localparam int BIT_NOCONN = 15;
   localparam int BIT_EVENT  = 7;
   localparam int BIT_IE     = 6;

   // Edge detector result
   typedef struct packed {
      logic raise;
      logic cancel;
   } edge_type;

endpackage

>>> hw/rtl/pbc_if.sv
// Channel interfaces: request, response and configuration write.
`timescale 1ns / 1ps

interface pbc_req_if;
   logic                              valid;
   logic                              ready;
   logic [pbc_pkg::ACTION_WIDTH-1:0]  action;
   logic [pbc_pkg::REG_WIDTH-1:0]     reg_index;
   logic [pbc_pkg::WORD_WIDTH-1:0]    write_data;
   logic                              panel_connected;
   logic [pbc_pkg::WORD_WIDTH-1:0]    changed_addr;

   modport source (output valid, action, reg_index, write_data, panel_connected,
                   changed_addr, input ready);
   modport sink   (input valid, action, reg_index, write_data, panel_connected,
                   changed_addr, output ready);
endinterface

interface pbc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pbc_pkg::WORD_WIDTH-1:0]    read_data;
   logic                              input_irq_raise;
   logic                              input_irq_cancel;
   logic                              output_irq_raise;
   logic                              output_irq_cancel;
   logic                              poll_strobe;
   logic                              update_strobe;
   logic [pbc_pkg::MODE_WIDTH-1:0]    test_mode;

   modport source (output valid, read_data, input_irq_raise, input_irq_cancel,
                   output_irq_raise, output_irq_cancel, poll_strobe,
                   update_strobe, test_mode, input ready);
   modport sink   (input valid, read_data, input_irq_raise, input_irq_cancel,
                   output_irq_raise, output_irq_cancel, poll_strobe,
                   update_strobe, test_mode, output ready);
endinterface

interface pbc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pbc_pkg::CSR_IDX_WIDTH-1:0] index;
   logic [pbc_pkg::WORD_WIDTH-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pbc_prescaler.sv
// Millisecond prescaler with clamped period; flags expiry on the stepping tick.
`timescale 1ns / 1ps

module pbc_prescaler #(
   parameter int PERIOD_MAX = pbc_pkg::PERIOD_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [pbc_pkg::WORD_WIDTH-1:0]  period,
   output logic                            expire
);

   localparam int CNT_WIDTH = (PERIOD_MAX < 2) ? 1 : $clog2(PERIOD_MAX + 1);
   localparam logic [pbc_pkg::WORD_WIDTH-1:0] PERIOD_CAP = pbc_pkg::WORD_WIDTH'(PERIOD_MAX);

   logic [CNT_WIDTH-1:0] prescale_ff, prescale_in;
   logic [CNT_WIDTH-1:0] eff_period;
   logic                 running;

   always_comb begin
      eff_period = (period > PERIOD_CAP) ? PERIOD_CAP[CNT_WIDTH-1:0] : period[CNT_WIDTH-1:0];
      running    = step && (eff_period != '0);
      expire     = running && !(prescale_ff < eff_period);
      prescale_in = prescale_ff;
      if (running) begin
         // reload also covers a period lowered below the count
         prescale_in = expire ? '0 : prescale_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
      end else begin
         prescale_ff <= prescale_in;
      end
   end

endmodule

>>> hw/rtl/panel_bridge_csr_device.sv
// Top level of the panel bridge CSR device: bus registers, prescalers, interrupt edges.
// Latency: a result is valid in the cycle after its request transaction is accepted.
// Throughput: one request per cycle; req ready drops only while a result waits unread.
// State updates and the result register load at the same edge, from one register pass.
// Reset (synchronous, active high) clears all bus state, loads default periods and
// configuration words, and empties the result register.
`timescale 1ns / 1ps

module panel_bridge_csr_device #(
   parameter int PERIOD_MAX = pbc_pkg::PERIOD_MAX_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   pbc_req_if.sink       req_ch,
   pbc_rsp_if.source     rsp_ch,
   pbc_csr_if.sink       csr_ch
);

   localparam int W = pbc_pkg::WORD_WIDTH;

   // Configuration registers
   logic [W-1:0] cfg_in_period_ff, cfg_out_period_ff, cfg_panel_word_ff;

   // Bus state
   logic         in_ie_ff, in_ie_in;
   logic         in_event_ff, in_event_in;
   logic         out_ie_ff, out_ie_in;
   logic         out_event_ff, out_event_in;
   logic [pbc_pkg::MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [W-1:0] in_period_ff, in_period_in;
   logic [W-1:0] out_period_ff, out_period_in;
   logic [W-1:0] change_ff, change_in;
   logic         in_prev_ff, in_prev_in;
   logic         out_prev_ff, out_prev_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rdata_ff, rdata_in;
   pbc_pkg::edge_type in_edge_ff, in_edge_in, out_edge_ff, out_edge_in;
   logic         poll_ff, poll_in, upd_ff, upd_in;
   logic [pbc_pkg::MODE_WIDTH-1:0] mode_out_ff;

   logic req_fire, is_tick;
   logic in_expire, out_expire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_tick      = req_fire && (req_ch.action == pbc_pkg::ACT_TICK);
   assign csr_ch.ready = 1'b1;

   pbc_prescaler #(.PERIOD_MAX(PERIOD_MAX)) u_in_prescaler (
      .clock  (clock),
      .reset  (reset),
      .step   (is_tick),
      .period (in_period_ff),
      .expire (in_expire)
   );

   pbc_prescaler #(.PERIOD_MAX(PERIOD_MAX)) u_out_prescaler (
      .clock  (clock),
      .reset  (reset),
      .step   (is_tick),
      .period (out_period_ff),
      .expire (out_expire)
   );

   function automatic pbc_pkg::edge_type edge_of(input logic level, input logic prev);
      pbc_pkg::edge_type e;
      e.raise  = level && !prev;
      e.cancel = !level && prev;
      return e;
   endfunction

   always_comb begin
      in_ie_in      = in_ie_ff;
      in_event_in   = in_event_ff;
      out_ie_in     = out_ie_ff;
      out_event_in  = out_event_ff;
      mode_in       = mode_ff;
      in_period_in  = in_period_ff;
      out_period_in = out_period_ff;
      change_in     = change_ff;
      in_prev_in    = in_prev_ff;
      out_prev_in   = out_prev_ff;
      rdata_in      = '0;
      in_edge_in    = '0;
      out_edge_in   = '0;
      poll_in       = 1'b0;
      upd_in        = 1'b0;

      unique case (req_ch.action)
         pbc_pkg::ACT_TICK: begin
            if (in_expire && req_ch.panel_connected) begin
               poll_in = 1'b1;
               if (req_ch.changed_addr != '0) begin
                  in_event_in = 1'b1;
                  change_in   = req_ch.changed_addr;
                  in_edge_in  = edge_of(in_ie_ff, in_prev_ff);
                  in_prev_in  = in_ie_ff;
               end
            end
            if (out_expire && req_ch.panel_connected) begin
               upd_in       = 1'b1;
               out_event_in = 1'b1;
               out_edge_in  = edge_of(out_ie_ff, out_prev_ff);
               out_prev_in  = out_ie_ff;
            end
         end
         pbc_pkg::ACT_READ: begin
            unique case (req_ch.reg_index)
               pbc_pkg::REG_ICS: begin
                  rdata_in[pbc_pkg::BIT_NOCONN] = !req_ch.panel_connected;
                  rdata_in[pbc_pkg::BIT_EVENT]  = in_event_ff;
                  rdata_in[pbc_pkg::BIT_IE]     = in_ie_ff;
                  in_event_in = 1'b0;
                  in_edge_in  = edge_of(1'b0, in_prev_ff);
                  in_prev_in  = 1'b0;
               end
               pbc_pkg::REG_OCS: begin
                  rdata_in[pbc_pkg::BIT_NOCONN] = !req_ch.panel_connected;
                  rdata_in[pbc_pkg::BIT_EVENT]  = out_event_ff;
                  rdata_in[pbc_pkg::BIT_IE]     = out_ie_ff;
                  rdata_in[pbc_pkg::MODE_WIDTH-1:0] = mode_ff;
                  out_event_in = 1'b0;
                  out_edge_in  = edge_of(1'b0, out_prev_ff);
                  out_prev_in  = 1'b0;
               end
               pbc_pkg::REG_IPER:       rdata_in = in_period_ff;
               pbc_pkg::REG_OPER:       rdata_in = out_period_ff;
               pbc_pkg::REG_CHANGE:     rdata_in = change_ff;
               pbc_pkg::REG_PANEL_WORD: rdata_in = cfg_panel_word_ff;
               default:                 rdata_in = '0;
            endcase
         end
         pbc_pkg::ACT_WRITE: begin
            unique case (req_ch.reg_index)
               pbc_pkg::REG_ICS: in_ie_in = req_ch.write_data[pbc_pkg::BIT_IE];
               pbc_pkg::REG_OCS: begin
                  out_ie_in = req_ch.write_data[pbc_pkg::BIT_IE];
                  mode_in   = req_ch.write_data[pbc_pkg::MODE_WIDTH-1:0];
               end
               pbc_pkg::REG_IPER: in_period_in  = req_ch.write_data;
               pbc_pkg::REG_OPER: out_period_in = req_ch.write_data;
               default: ;
            endcase
         end
         default: begin
            // bus init: prescalers keep counting from where they are
            in_ie_in      = 1'b0;
            in_event_in   = 1'b0;
            out_ie_in     = 1'b0;
            out_event_in  = 1'b0;
            mode_in       = '0;
            in_period_in  = cfg_in_period_ff;
            out_period_in = cfg_out_period_ff;
            change_in     = '0;
            in_prev_in    = 1'b0;
            out_prev_in   = 1'b0;
         end
      endcase

      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_in_period_ff  <= pbc_pkg::CFG_IN_PERIOD_RESET;
         cfg_out_period_ff <= pbc_pkg::CFG_OUT_PERIOD_RESET;
         cfg_panel_word_ff <= pbc_pkg::CFG_PANEL_WORD_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pbc_pkg::CFG_IN_PERIOD:  cfg_in_period_ff  <= csr_ch.data;
            pbc_pkg::CFG_OUT_PERIOD: cfg_out_period_ff <= csr_ch.data;
            pbc_pkg::CFG_PANEL_WORD: cfg_panel_word_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ie_ff      <= 1'b0;
         in_event_ff   <= 1'b0;
         out_ie_ff     <= 1'b0;
         out_event_ff  <= 1'b0;
         mode_ff       <= '0;
         in_period_ff  <= pbc_pkg::CFG_IN_PERIOD_RESET;
         out_period_ff <= pbc_pkg::CFG_OUT_PERIOD_RESET;
         change_ff     <= '0;
         in_prev_ff    <= 1'b0;
         out_prev_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            in_ie_ff      <= in_ie_in;
            in_event_ff   <= in_event_in;
            out_ie_ff     <= out_ie_in;
            out_event_ff  <= out_event_in;
            mode_ff       <= mode_in;
            in_period_ff  <= in_period_in;
            out_period_ff <= out_period_in;
            change_ff     <= change_in;
            in_prev_ff    <= in_prev_in;
            out_prev_ff   <= out_prev_in;
         end
      end
   end

   // Load the result payload only with a new transaction; hold it while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rdata_ff    <= rdata_in;
         in_edge_ff  <= in_edge_in;
         out_edge_ff <= out_edge_in;
         poll_ff     <= poll_in;
         upd_ff      <= upd_in;
         mode_out_ff <= mode_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.read_data         = rdata_ff;
   assign rsp_ch.input_irq_raise   = in_edge_ff.raise;
   assign rsp_ch.input_irq_cancel  = in_edge_ff.cancel;
   assign rsp_ch.output_irq_raise  = out_edge_ff.raise;
   assign rsp_ch.output_irq_cancel = out_edge_ff.cancel;
   assign rsp_ch.poll_strobe       = poll_ff;
   assign rsp_ch.update_strobe     = upd_ff;
   assign rsp_ch.test_mode         = mode_out_ff;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("request accepted while result stalled");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.action == pbc_pkg::ACT_INIT) |=>
      (!in_edge_ff.raise && !in_edge_ff.cancel && !out_edge_ff.raise &&
       !out_edge_ff.cancel && !in_event_ff && !out_event_ff && !in_prev_ff && !out_prev_ff))
      else $error("bus init left events or interrupt edges");

   a_read_clears_event: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.action == pbc_pkg::ACT_READ &&
       req_ch.reg_index == pbc_pkg::REG_ICS) |=> (!in_event_ff && !in_prev_ff))
      else $error("ICS read did not clear input event");

endmodule
